// ===== rtl/core/cam_pkg.sv =====
// Shared types, constants and codes of the capture-aware move orderer.
package cam_pkg;

    localparam int LIST_DEPTH_DEF = 256;

    localparam int SQ_W        = 6;
    localparam int KIND_W      = 4;
    localparam int MOVE_W      = 16;
    localparam int SCORE_W     = 15;
    localparam int RANK_W      = 2;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 4;
    localparam int KILLER_W    = 33;
    localparam int KILLER_VLD  = 32;
    localparam int NUM_PIECES  = 6;
    localparam int NUM_VICTIMS = 5;
    localparam int PIECE_W     = 3;

    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic [MOVE_W-1:0]         t_move;
    typedef logic [RANK_W-1:0]         t_rank;

    typedef struct packed {
        t_move  move;
        t_score score;
        t_rank  rank;
    } t_entry;

    // Move kinds
    localparam logic [KIND_W-1:0] KIND_QUIET   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_CAPTURE = 4'd1;
    localparam logic [KIND_W-1:0] KIND_PROMO_N = 4'd2;
    localparam logic [KIND_W-1:0] KIND_PROMO_Q = 4'd5;
    localparam logic [KIND_W-1:0] KIND_PCAP_N  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_PCAP_Q  = 4'd9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAWN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KING   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HASH   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KILLER = 4'd7;

    // Quiet ranks
    localparam t_rank RANK_NONE   = 2'd0;
    localparam t_rank RANK_KILLER = 2'd1;
    localparam t_rank RANK_MATE   = 2'd2;

    localparam t_score HASH_BONUS = 15'sd10000;

    localparam t_score MVV_LVA [NUM_VICTIMS][NUM_PIECES] = '{
        '{15'sd500,  15'sd400,  15'sd300,  15'sd200,  15'sd100,  15'sd600},
        '{15'sd1100, 15'sd1000, 15'sd900,  15'sd800,  15'sd700,  15'sd1200},
        '{15'sd1700, 15'sd1600, 15'sd1500, 15'sd1400, 15'sd1300, 15'sd1800},
        '{15'sd2300, 15'sd2200, 15'sd2100, 15'sd2000, 15'sd1900, 15'sd2400},
        '{15'sd2900, 15'sd2800, 15'sd2700, 15'sd2600, 15'sd2500, 15'sd3000}
    };

    localparam t_score PROMO_ADJ [4] = '{-15'sd1000, -15'sd2000, -15'sd3000, 15'sd1000};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SCAN,
        ST_WB_HEAD,
        ST_WB_SWAP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic fetch;
        logic head;
        logic scan;
        logic wb_head;
        logic wb_swap;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic list_done;
        logic head_last;
        logic scan_last;
        logic found;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/cam_in_if.sv =====
// Request channel: load or fetch requests with the move to load.
interface cam_in_if;
    import cam_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic              first_of_list;
    logic [SQ_W-1:0]   move_from;
    logic [SQ_W-1:0]   move_to;
    logic [KIND_W-1:0] move_kind;

    modport source (
        output valid, req_type, first_of_list, move_from, move_to, move_kind,
        input  ready
    );

    modport sink (
        input  valid, req_type, first_of_list, move_from, move_to, move_kind,
        output ready
    );
endinterface

// ===== rtl/core/cam_out_if.sv =====
// Result channel: fetched move with its ordering score and list flags.
interface cam_out_if;
    import cam_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [SQ_W-1:0]           out_from;
    logic [SQ_W-1:0]           out_to;
    logic [KIND_W-1:0]         out_kind;
    logic signed [SCORE_W-1:0] out_score;
    logic                      is_last;
    logic                      none_left;

    modport source (
        output valid, out_from, out_to, out_kind, out_score, is_last, none_left,
        input  ready
    );

    modport sink (
        input  valid, out_from, out_to, out_kind, out_score, is_last, none_left,
        output ready
    );
endinterface

// ===== rtl/core/cam_scorer.sv =====
// Move scorer: hash bonus, MVV/LVA lookup, promotion adjustment and killer rank.
module cam_scorer (
    input  logic [cam_pkg::NUM_PIECES-1:0][cam_pkg::CFG_W-1:0] i_occ,
    input  logic [cam_pkg::MOVE_W-1:0]                         i_hash,
    input  logic [cam_pkg::KILLER_W-1:0]                       i_killer,
    input  logic [cam_pkg::SQ_W-1:0]                           i_from,
    input  logic [cam_pkg::SQ_W-1:0]                           i_to,
    input  logic [cam_pkg::KIND_W-1:0]                         i_kind,
    output cam_pkg::t_entry                                    o_entry
);
    import cam_pkg::*;

    logic [PIECE_W-1:0] attacker;
    logic [PIECE_W-1:0] victim;
    t_move              packed_move;
    logic               is_cap;
    logic               is_promo;
    logic               is_pcap;
    logic [KIND_W-1:0]  promo_off;
    t_score             score;
    t_rank              rank;

    assign packed_move = {i_from, i_to, i_kind};

    // Lowest piece index wins; an empty square counts as a pawn
    always_comb begin
        attacker = '0;
        for (int t = NUM_PIECES - 1; t >= 0; t--) begin
            if (i_occ[t][i_from]) begin
                attacker = PIECE_W'(t);
            end
        end
    end

    always_comb begin
        victim = '0;
        for (int t = NUM_VICTIMS - 1; t >= 0; t--) begin
            if (i_occ[t][i_to]) begin
                victim = PIECE_W'(t);
            end
        end
    end

    assign is_pcap  = (i_kind >= KIND_PCAP_N) && (i_kind <= KIND_PCAP_Q);
    assign is_promo = (i_kind >= KIND_PROMO_N) && (i_kind <= KIND_PROMO_Q);
    assign is_cap   = (i_kind == KIND_CAPTURE) || is_pcap;
    assign promo_off = is_pcap ? (i_kind - KIND_PCAP_N) : (i_kind - KIND_PROMO_N);

    always_comb begin
        score = '0;
        if (packed_move == i_hash) begin
            score = HASH_BONUS;
        end
        if (is_cap) begin
            score = score + MVV_LVA[victim][attacker];
        end
        if (is_pcap || is_promo) begin
            score = score + PROMO_ADJ[promo_off[1:0]];
        end
    end

    always_comb begin
        rank = RANK_NONE;
        if (i_kind == KIND_QUIET && i_killer[KILLER_VLD]) begin
            if (packed_move == i_killer[2*MOVE_W-1:MOVE_W]) begin
                rank = RANK_MATE;
            end else if (packed_move == i_killer[MOVE_W-1:0]) begin
                rank = RANK_KILLER;
            end
        end
    end

    assign o_entry = '{move: packed_move, score: score, rank: rank};

endmodule

// ===== rtl/core/cam_datapath.sv =====
// Datapath: board registers, move list memory, selection scan and result register.
module cam_datapath #(
    parameter int LIST_DEPTH = cam_pkg::LIST_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cam_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cam_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_first,
    input  logic [cam_pkg::SQ_W-1:0]          i_from,
    input  logic [cam_pkg::SQ_W-1:0]          i_to,
    input  logic [cam_pkg::KIND_W-1:0]        i_kind,
    input  cam_pkg::t_cmd                     i_cmd,
    output cam_pkg::t_sts                     o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [cam_pkg::SQ_W-1:0]          o_out_from,
    output logic [cam_pkg::SQ_W-1:0]          o_out_to,
    output logic [cam_pkg::KIND_W-1:0]        o_out_kind,
    output logic signed [cam_pkg::SCORE_W-1:0] o_out_score,
    output logic                              o_is_last,
    output logic                              o_none_left
);
    import cam_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [NUM_PIECES-1:0][CFG_W-1:0] r_occ;
    t_move                            r_hash;
    logic [KILLER_W-1:0]              r_killer;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_cur;

    t_entry        r_mem [LIST_DEPTH];
    t_entry        r_rdata;

    t_entry        r_head;
    t_entry        r_s_entry;
    t_entry        r_r_entry;
    logic [AW-1:0] r_s_idx;
    logic [AW-1:0] r_r_idx;
    t_score        r_best_score;
    t_rank         r_best_rank;
    logic          r_quiet_head;
    logic          r_s_found;
    logic          r_r_found;
    logic          r_none;

    logic          r_ov;
    logic [SQ_W-1:0]   r_o_from;
    logic [SQ_W-1:0]   r_o_to;
    logic [KIND_W-1:0] r_o_kind;
    t_score            r_o_score;
    logic              r_o_last;
    logic              r_o_none;

    t_entry        new_entry;
    t_entry        win_entry;
    logic [AW-1:0] win_idx;
    logic          we;
    logic [AW-1:0] waddr;
    t_entry        wdata;
    logic [CW-1:0] raddr_full;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] cur_inc;

    cam_scorer u_scorer (
        .i_occ    (r_occ),
        .i_hash   (r_hash),
        .i_killer (r_killer),
        .i_from   (i_from),
        .i_to     (i_to),
        .i_kind   (i_kind),
        .o_entry  (new_entry)
    );

    // Drop writes to indexes past the last register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_hash   <= '0;
            r_killer <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx <= REG_KING) begin
                r_occ[i_cfg_idx[PIECE_W-1:0]] <= i_cfg_data;
            end else if (i_cfg_idx == REG_HASH) begin
                r_hash <= i_cfg_data[MOVE_W-1:0];
            end else if (i_cfg_idx == REG_KILLER) begin
                r_killer <= i_cfg_data[KILLER_W-1:0];
            end
        end
    end

    assign pos_inc = r_pos + ONE_C;
    assign cur_inc = r_cur + ONE_C;

    always_comb begin
        if (r_s_found) begin
            win_entry = r_s_entry;
            win_idx   = r_s_idx;
        end else if (r_r_found) begin
            win_entry = r_r_entry;
            win_idx   = r_r_idx;
        end else begin
            win_entry = r_head;
            win_idx   = r_pos[AW-1:0];
        end
    end

    // Single write port: load, then the two halves of the swap
    always_comb begin
        we    = 1'b0;
        waddr = r_pos[AW-1:0];
        wdata = new_entry;
        if (i_cmd.load) begin
            we    = i_first || (r_count != DEPTH_C);
            waddr = i_first ? '0 : r_count[AW-1:0];
            wdata = new_entry;
        end else if (i_cmd.wb_head) begin
            we    = 1'b1;
            waddr = r_pos[AW-1:0];
            wdata = win_entry;
        end else if (i_cmd.wb_swap) begin
            we    = 1'b1;
            waddr = win_idx;
            wdata = r_head;
        end
    end

    // Read ahead: the head entry while idle, then one entry a cycle during the scan
    always_comb begin
        priority if (i_cmd.scan) begin
            raddr_full = cur_inc;
        end else if (i_cmd.head) begin
            raddr_full = pos_inc;
        end else begin
            raddr_full = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr_full[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos   <= '0;
        end else if (i_cmd.load) begin
            if (i_first) begin
                r_count <= ONE_C;
                r_pos   <= '0;
            end else if (r_count != DEPTH_C) begin
                r_count <= r_count + ONE_C;
            end
        end else if (i_cmd.out_load && !r_none) begin
            r_pos <= pos_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_found <= 1'b0;
            r_r_found <= 1'b0;
            r_none    <= 1'b0;
        end else begin
            if (i_cmd.fetch) begin
                r_none <= o_sts.list_done;
            end
            if (i_cmd.head) begin
                r_s_found <= 1'b0;
                r_r_found <= 1'b0;
            end else if (i_cmd.scan) begin
                if ($signed(r_rdata.score) > $signed(r_best_score)) begin
                    r_s_found <= 1'b1;
                end else if (r_quiet_head && !r_s_found && r_rdata.rank > r_best_rank) begin
                    r_r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.head) begin
            r_head       <= r_rdata;
            r_best_score <= r_rdata.score;
            r_best_rank  <= r_rdata.rank;
            r_quiet_head <= (r_rdata.move[KIND_W-1:0] == KIND_QUIET);
            r_cur        <= pos_inc;
        end else if (i_cmd.scan) begin
            r_cur <= cur_inc;
            if ($signed(r_rdata.score) > $signed(r_best_score)) begin
                r_best_score <= r_rdata.score;
                r_s_entry    <= r_rdata;
                r_s_idx      <= r_cur[AW-1:0];
            end else if (r_quiet_head && !r_s_found && r_rdata.rank > r_best_rank) begin
                r_best_rank <= r_rdata.rank;
                r_r_entry   <= r_rdata;
                r_r_idx     <= r_cur[AW-1:0];
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_none) begin
                r_o_from  <= '0;
                r_o_to    <= '0;
                r_o_kind  <= '0;
                r_o_score <= '0;
                r_o_last  <= 1'b0;
                r_o_none  <= 1'b1;
            end else begin
                r_o_from  <= win_entry.move[MOVE_W-1:MOVE_W-SQ_W];
                r_o_to    <= win_entry.move[KIND_W+SQ_W-1:KIND_W];
                r_o_kind  <= win_entry.move[KIND_W-1:0];
                r_o_score <= win_entry.score;
                r_o_last  <= (pos_inc == r_count);
                r_o_none  <= 1'b0;
            end
        end
    end

    assign o_sts.list_done = (r_pos >= r_count);
    assign o_sts.head_last = (pos_inc == r_count);
    assign o_sts.scan_last = (cur_inc == r_count);
    assign o_sts.found     = r_s_found || r_r_found;
    assign o_sts.out_free  = !r_ov || i_out_ready;

    assign o_out_valid = r_ov;
    assign o_out_from  = r_o_from;
    assign o_out_to    = r_o_to;
    assign o_out_kind  = r_o_kind;
    assign o_out_score = r_o_score;
    assign o_is_last   = r_o_last;
    assign o_none_left = r_o_none;

endmodule

// ===== rtl/core/cam_ctrl.sv =====
// Controller: sequences loads, the selection scan, the swap write-back and the result.
module cam_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_req_fetch,
    input  cam_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output cam_pkg::t_cmd o_cmd
);
    import cam_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_req_fetch) begin
                    n_state = i_sts.list_done ? ST_OUT : ST_HEAD;
                end
            end
            ST_HEAD: begin
                n_state = i_sts.head_last ? ST_OUT : ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = ST_WB_HEAD;
                end
            end
            ST_WB_HEAD: begin
                n_state = i_sts.found ? ST_WB_SWAP : ST_OUT;
            end
            ST_WB_SWAP: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load  = i_in_valid && !i_req_fetch;
                o_cmd.fetch = i_in_valid && i_req_fetch;
            end
            ST_HEAD:    o_cmd.head     = 1'b1;
            ST_SCAN:    o_cmd.scan     = 1'b1;
            ST_WB_HEAD: o_cmd.wb_head  = i_sts.found;
            ST_WB_SWAP: o_cmd.wb_swap  = 1'b1;
            ST_OUT:     o_cmd.out_load = i_sts.out_free;
            default:    o_cmd          = '0;
        endcase
    end

endmodule

// ===== rtl/core/capture_aware_move_orderer_core.sv =====
// Move orderer: scores moves as they are loaded and returns them best first.
//
// Channels: i_in takes requests; req_type 0 loads one move (first_of_list
// empties the list first), req_type 1 fetches the next ordered move. o_out
// carries one result per fetch and none per load. Board occupancy, hash move
// and killer moves are written on the plain port i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must do so only while the block is idle; the block does not enforce it.
// Fetch: a fetch at list position p of an n-entry list reads the head entry,
// then one entry a cycle over positions p+1 to n-1 through the single read
// port of the list memory, then, when a better move turned up, writes the
// winner to position p and the displaced entry to the winner's old slot in
// the write-back and swap states, and loads the result register once it is
// free. A fetch of the last entry skips the scan and the write-back; a fetch
// past the end goes straight to the result and returns none_left.
// The result waits in an output register; loads are still taken while it
// waits, and a further fetch completes its scan and holds in its final state
// until the register is free.
// Reset clears the board registers, the list count and the fetch position;
// the list memory itself is not cleared and needs no clearing pass.
module capture_aware_move_orderer_core #(
    parameter int LIST_DEPTH = cam_pkg::LIST_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cam_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cam_pkg::CFG_W-1:0]     i_cfg_data,
    cam_in_if.sink                        i_in,
    cam_out_if.source                     o_out
);
    import cam_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cam_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_req_fetch (i_in.req_type),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_cmd       (cmd)
    );

    cam_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_first     (i_in.first_of_list),
        .i_from      (i_in.move_from),
        .i_to        (i_in.move_to),
        .i_kind      (i_in.move_kind),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_from  (o_out.out_from),
        .o_out_to    (o_out.out_to),
        .o_out_kind  (o_out.out_kind),
        .o_out_score (o_out.out_score),
        .o_is_last   (o_out.is_last),
        .o_none_left (o_out.none_left)
    );

endmodule

// ===== rtl/core/cam_checker.sv =====
// Port-level checker of the move orderer and its bind to the top level.
module cam_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_req_type,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [cam_pkg::SQ_W-1:0]           i_out_from,
    input logic [cam_pkg::SQ_W-1:0]           i_out_to,
    input logic [cam_pkg::KIND_W-1:0]         i_out_kind,
    input logic signed [cam_pkg::SCORE_W-1:0] i_out_score,
    input logic                               i_is_last,
    input logic                               i_none_left
);

    // Reset empties the result register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_from)
            && $stable(i_out_to) && $stable(i_out_kind) && $stable(i_out_score)
            && $stable(i_is_last) && $stable(i_none_left))
        else $error("stalled result changed");

    // A load never raises a result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_req_type && !i_out_valid |=> !i_out_valid)
        else $error("result after a load");

    // A fetch occupies the block for at least the next cycle
    a_fetch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_req_type |=> !i_in_ready)
        else $error("request taken straight after a fetch");

    // An empty fetch returns all-zero fields
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_none_left |-> i_out_from == '0 && i_out_to == '0
            && i_out_kind == '0 && i_out_score == '0 && !i_is_last)
        else $error("empty fetch with non-zero fields");

endmodule

bind capture_aware_move_orderer_core cam_checker u_cam_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_req_type  (i_in.req_type),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_from  (o_out.out_from),
    .i_out_to    (o_out.out_to),
    .i_out_kind  (o_out.out_kind),
    .i_out_score (o_out.out_score),
    .i_is_last   (o_out.is_last),
    .i_none_left (o_out.none_left)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the move orderer: move scoring, best-first selection and list handling.
module tb;
    import cam_pkg::*;

    localparam int   DEPTH            = LIST_DEPTH_DEF;
    localparam logic REQ_LOAD         = 1'b0;
    localparam logic REQ_FETCH        = 1'b1;
    localparam int   HASH_MATCH_BONUS = 10000;
    localparam int   PROMO_SCORE [4]  = '{-1000, -2000, -3000, 1000};
    localparam int   GAP_MAX          = 19;
    localparam int   HOLD_CYCLES      = 8;
    localparam int   STALL_LIMIT      = 4000;
    localparam int   ITEM_TARGET      = 1200;

    // Opening position, plus a pawn and a queen sharing square 20
    localparam logic [CFG_W-1:0] OPENING [NUM_PIECES] = '{
        64'h00FF_0000_0010_FF00,
        64'h4200_0000_0000_0042,
        64'h2400_0000_0000_0024,
        64'h8100_0000_0000_0081,
        64'h0800_0000_0010_0008,
        64'h1000_0000_0000_0010
    };

    typedef enum int {
        BOARD_CLEAR,
        BOARD_FULL,
        BOARD_SPARSE,
        BOARD_DENSE
    } t_board_mode;

    typedef struct {
        logic [SQ_W-1:0]   from_sq;
        logic [SQ_W-1:0]   to_sq;
        logic [KIND_W-1:0] kind;
        t_score            score;
        logic              last;
        logic              empty;
    } t_fetched;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    cam_in_if  req_if ();
    cam_out_if res_if ();

    capture_aware_move_orderer_core #(
        .LIST_DEPTH (DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (req_if),
        .o_out      (res_if)
    );

    // Predicted copy of the board registers and the move list
    logic [CFG_W-1:0]    board [NUM_PIECES];
    t_move               hash_reg;
    logic [KILLER_W-1:0] killer_reg;
    t_move               list_move  [DEPTH];
    int                  list_score [DEPTH];
    t_rank               list_rank  [DEPTH];
    int                  list_len = 0;
    int                  next_pos = 0;

    t_fetched expected_fetches [$];
    int       errors      = 0;
    int       items_sent  = 0;
    int       quiet_cycles = 0;
    bit       no_idle     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_draw();
        return no_idle ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic int piece_on(logic [SQ_W-1:0] sq, int kinds);
        for (int t = 0; t < kinds; t++) begin
            if (board[t][sq]) return t;
        end
        return 0;
    endfunction

    function automatic int capture_value(logic [SQ_W-1:0] from_sq, logic [SQ_W-1:0] to_sq);
        int att;
        int vic;
        att = piece_on(from_sq, NUM_PIECES);
        vic = piece_on(to_sq, NUM_VICTIMS);
        // a king taking outranks every other attacker on the same victim
        return 600 * vic + ((att == NUM_PIECES - 1) ? 600 : 500 - 100 * att);
    endfunction

    // Score one loaded move and append it; returns 0 when the list is full
    function automatic bit store_scored_move(logic first, t_move m);
        logic [KIND_W-1:0] kind;
        int                score;
        t_rank             rank;
        kind  = m[KIND_W-1:0];
        score = 0;
        rank  = RANK_NONE;
        if (first) begin
            list_len = 0;
            next_pos = 0;
        end
        if (list_len >= DEPTH) return 1'b0;
        if (m == hash_reg) score += HASH_MATCH_BONUS;
        if (kind == KIND_CAPTURE || (kind >= KIND_PCAP_N && kind <= KIND_PCAP_Q)) begin
            score += capture_value(m[MOVE_W-1:MOVE_W-SQ_W], m[KIND_W+SQ_W-1:KIND_W]);
            if (kind != KIND_CAPTURE) score += PROMO_SCORE[kind - KIND_PCAP_N];
        end else if (kind >= KIND_PROMO_N && kind <= KIND_PROMO_Q) begin
            score += PROMO_SCORE[kind - KIND_PROMO_N];
        end else if (kind == KIND_QUIET && killer_reg[KILLER_VLD]) begin
            if (m == killer_reg[2*MOVE_W-1:MOVE_W]) rank = RANK_MATE;
            else if (m == killer_reg[MOVE_W-1:0]) rank = RANK_KILLER;
        end
        list_move[list_len]  = m;
        list_score[list_len] = score;
        list_rank[list_len]  = rank;
        list_len++;
        return 1'b1;
    endfunction

    // One selection pass from the fetch position; queue the move it returns
    function automatic void select_best();
        t_fetched f;
        int       p;
        int       s_idx;
        int       r_idx;
        int       pick;
        int       best_s;
        t_rank    best_r;
        bit       head_quiet;
        t_move    m;
        int       s;
        t_rank    r;
        f = '{default: 0};
        if (next_pos >= list_len || next_pos >= DEPTH) begin
            f.empty = 1'b1;
            expected_fetches.push_back(f);
            return;
        end
        p          = next_pos;
        s_idx      = p;
        r_idx      = p;
        best_s     = list_score[p];
        best_r     = list_rank[p];
        head_quiet = (list_move[p][KIND_W-1:0] == KIND_QUIET);
        for (int j = p + 1; j < list_len; j++) begin
            if (list_score[j] > best_s) begin
                best_s = list_score[j];
                s_idx  = j;
            end else if (head_quiet && s_idx == p && list_rank[j] > best_r) begin
                best_r = list_rank[j];
                r_idx  = j;
            end
        end
        // a higher score beats a rank candidate
        pick = (s_idx != p) ? s_idx : r_idx;
        m = list_move[pick];
        s = list_score[pick];
        r = list_rank[pick];
        list_move[pick]  = list_move[p];
        list_score[pick] = list_score[p];
        list_rank[pick]  = list_rank[p];
        list_move[p]     = m;
        list_score[p]    = s;
        list_rank[p]     = r;
        f.from_sq = m[MOVE_W-1:MOVE_W-SQ_W];
        f.to_sq   = m[KIND_W+SQ_W-1:KIND_W];
        f.kind    = m[KIND_W-1:0];
        f.score   = t_score'(s);
        f.last    = (p + 1 == list_len);
        next_pos  = p + 1;
        expected_fetches.push_back(f);
    endfunction

    function automatic t_move killer_pick();
        t_move m;
        m = t_move'($urandom);
        if ($urandom_range(0, 4) != 0) m[KIND_W-1:0] = KIND_QUIET;
        return m;
    endfunction

    function automatic t_move random_move();
        t_move m;
        case ($urandom_range(0, 9))
            0: m = hash_reg;
            1: m = killer_reg[MOVE_W-1:0];
            2: m = killer_reg[2*MOVE_W-1:MOVE_W];
            default: begin
                m = t_move'($urandom);
                if ($urandom_range(0, 2) == 0) m[KIND_W-1:0] = KIND_QUIET;
                else if ($urandom_range(0, 2) == 0) m[KIND_W-1:0] = KIND_CAPTURE;
            end
        endcase
        return m;
    endfunction

    function automatic void compare_field(string name, logic signed [31:0] exp_v,
                                          logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    task automatic check_result();
        t_fetched e;
        if (expected_fetches.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual from %0d to %0d kind %0d score %0d",
                     $time, res_if.out_from, res_if.out_to, res_if.out_kind, res_if.out_score);
            return;
        end
        e = expected_fetches.pop_front();
        compare_field("out_from", e.from_sq, res_if.out_from);
        compare_field("out_to", e.to_sq, res_if.out_to);
        compare_field("out_kind", e.kind, res_if.out_kind);
        compare_field("out_score", e.score, res_if.out_score);
        compare_field("is_last", e.last, res_if.is_last);
        compare_field("none_left", e.empty, res_if.none_left);
    endtask

    // Result side: random stall between transfers, check each one
    initial begin : result_side
        int   stall;
        logic rdy_next;
        res_if.ready <= 1'b0;
        stall = 3;
        forever begin
            @(posedge i_clk);
            rdy_next = res_if.ready;
            if (res_if.valid && res_if.ready) begin
                check_result();
                stall    = gap_draw();
                rdy_next = (stall == 0);
            end else if (!res_if.ready) begin
                if (stall > 0) stall--;
                if (stall == 0) rdy_next = 1'b1;
            end
            res_if.ready <= rdy_next;
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(logic req, logic first, t_move m);
        int gap;
        gap = gap_draw();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.req_type      <= req;
        req_if.first_of_list <= first;
        req_if.move_from     <= m[MOVE_W-1:MOVE_W-SQ_W];
        req_if.move_to       <= m[KIND_W+SQ_W-1:KIND_W];
        req_if.move_kind     <= m[KIND_W-1:0];
        do @(posedge i_clk); while (!req_if.ready);
        if (req == REQ_LOAD) begin
            if (store_scored_move(first, m)) items_sent++;
        end else begin
            select_best();
            items_sent++;
        end
    endtask

    task automatic fetch_next();
        send_request(REQ_FETCH, 1'($urandom), t_move'($urandom));
    endtask

    // Hold the request side until every fetch has been answered
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_fetches.size() != 0);
    endtask

    task automatic settle();
        drain_results();
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        if (idx < NUM_PIECES) board[idx] = data;
        else if (idx == REG_HASH) hash_reg = data[MOVE_W-1:0];
        else if (idx == REG_KILLER) killer_reg = data[KILLER_W-1:0];
    endtask

    task automatic program_regs(t_board_mode mode);
        logic [CFG_W-1:0]    occ;
        t_move               hm;
        logic [KILLER_W-1:0] kp;
        logic                kv;
        settle();
        for (int i = 0; i < NUM_PIECES; i++) begin
            case (mode)
                BOARD_CLEAR:  occ = '0;
                BOARD_FULL:   occ = '1;
                BOARD_SPARSE: occ = {$urandom, $urandom} & {$urandom, $urandom}
                                    & {$urandom, $urandom};
                default:      occ = {$urandom, $urandom};
            endcase
            write_reg(REG_PAWN + CFG_IDX_W'(i), occ);
        end
        case (mode)
            BOARD_CLEAR: begin
                hm = '0;
                kp = '0;
            end
            BOARD_FULL: begin
                hm = '1;
                kp = '1;
            end
            default: begin
                hm = ($urandom_range(0, 3) == 0) ? killer_pick() : t_move'($urandom);
                kv = ($urandom_range(0, 3) != 0);
                kp = {kv, killer_pick(), killer_pick()};
            end
        endcase
        write_reg(REG_HASH, CFG_W'(hm));
        write_reg(REG_KILLER, CFG_W'(kp));
        cfg_we <= 1'b0;
    endtask

    task automatic test_empty_fetch();
        fetch_next();
    endtask

    task automatic test_scoring();
        settle();
        // an index past the last register must change nothing
        write_reg(REG_KILLER + CFG_IDX_W'($urandom_range(1, 8)), {$urandom, $urandom});
        for (int i = 0; i < NUM_PIECES; i++) write_reg(REG_PAWN + CFG_IDX_W'(i), OPENING[i]);
        write_reg(REG_HASH, CFG_W'({6'd3, 6'd60, KIND_CAPTURE}));
        write_reg(REG_KILLER, CFG_W'({1'b1, 6'd12, 6'd28, KIND_QUIET, 6'd11, 6'd27, KIND_QUIET}));
        cfg_we <= 1'b0;
        // hash capture onto the king square: bonus plus a pawn victim
        send_request(REQ_LOAD, 1'b1, {6'd3, 6'd60, KIND_CAPTURE});
        // attacker square empty
        send_request(REQ_LOAD, 1'b0, {6'd30, 6'd63, KIND_CAPTURE});
        // shared square counts as its pawn
        send_request(REQ_LOAD, 1'b0, {6'd20, 6'd59, KIND_CAPTURE});
        for (int i = 0; i < 4; i++) begin
            send_request(REQ_LOAD, 1'b0, {6'd52, 6'd60, KIND_PROMO_N + KIND_W'(i)});
        end
        // victim square empty on the first promotion capture
        send_request(REQ_LOAD, 1'b0, {6'd51, 6'd40, KIND_PCAP_N});
        send_request(REQ_LOAD, 1'b0, {6'd51, 6'd58, KIND_PCAP_N + KIND_W'(1)});
        send_request(REQ_LOAD, 1'b0, {6'd51, 6'd56, KIND_PCAP_N + KIND_W'(2)});
        send_request(REQ_LOAD, 1'b0, {6'd51, 6'd59, KIND_PCAP_Q});
        send_request(REQ_LOAD, 1'b0, {6'd10, 6'd26, KIND_PCAP_Q + KIND_W'(3)});
        send_request(REQ_LOAD, 1'b0, {6'd11, 6'd27, KIND_QUIET});
        send_request(REQ_LOAD, 1'b0, {6'd12, 6'd28, KIND_QUIET});
        // drain the list and one past its end
        repeat (15) fetch_next();
    endtask

    task automatic test_list_full();
        program_regs(BOARD_DENSE);
        send_request(REQ_LOAD, 1'b1, random_move());
        // the last three loads find the list full
        repeat (DEPTH + 2) send_request(REQ_LOAD, 1'b0, random_move());
        repeat (DEPTH + 1) fetch_next();
    endtask

    task automatic test_random_lists();
        int          phase;
        int          size;
        int          fetches;
        t_board_mode mode;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase < 2 || $urandom_range(0, 2) == 0) begin
                if (phase == 0) mode = BOARD_FULL;
                else if (phase == 1) mode = BOARD_CLEAR;
                else mode = t_board_mode'($urandom_range(0, 3));
                program_regs(mode);
            end
            no_idle = ($urandom_range(0, 4) == 0);
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            for (int i = 0; i < size; i++) begin
                send_request(REQ_LOAD, (i == 0) && ($urandom_range(0, 9) != 0), random_move());
            end
            fetches = $urandom_range(0, size + 2);
            for (int i = 0; i < fetches; i++) begin
                case ($urandom_range(0, 19))
                    0, 1: send_request(REQ_LOAD, 1'b0, random_move());
                    2: send_request(REQ_LOAD, 1'b1, random_move());
                    3: drain_results();
                    default: ;
                endcase
                fetch_next();
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_data             <= '0;
        req_if.valid         <= 1'b0;
        req_if.req_type      <= REQ_LOAD;
        req_if.first_of_list <= 1'b0;
        req_if.move_from     <= '0;
        req_if.move_to       <= '0;
        req_if.move_kind     <= KIND_QUIET;
        for (int i = 0; i < NUM_PIECES; i++) board[i] = '0;
        hash_reg   = '0;
        killer_reg = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_fetch();
        test_scoring();
        test_list_full();
        test_random_lists();
        drain_results();
        repeat (DEPTH + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cam_pkg.sv
rtl/core/cam_in_if.sv
rtl/core/cam_out_if.sv
rtl/core/cam_scorer.sv
rtl/core/cam_datapath.sv
rtl/core/cam_ctrl.sv
rtl/core/capture_aware_move_orderer_core.sv
rtl/core/cam_checker.sv
test/tb.sv
